// ===== rtl/core/bcp_pkg.sv =====
package bcp_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS      = 24;
	localparam int CORDIC_STEPS   = 28;
	localparam int ZW             = 34;

	localparam logic [29:0] GAIN_INV = 30'd652032874;
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

	typedef logic [1:0] pt_idx_t;

	// pair order 12, 13, 14, 23, 24, 34
	function automatic pt_idx_t pair_a(input int p);
		case (p)
			0, 1, 2: pair_a = 2'd0;
			3, 4:    pair_a = 2'd1;
			default: pair_a = 2'd2;
		endcase
	endfunction

	function automatic pt_idx_t pair_b(input int p);
		case (p)
			0:       pair_b = 2'd1;
			1, 3:    pair_b = 2'd2;
			default: pair_b = 2'd3;
		endcase
	endfunction

	function automatic int pair_of(input int a, input int k);
		int lo;
		int hi;
		lo = (a < k) ? a : k;
		hi = (a < k) ? k : a;
		pair_of = (lo == 0) ? hi - 1 : ((lo == 1) ? hi + 1 : 5);
	endfunction

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		case (i)
			0:  atan_turn = ZW'(64'sd536870912);
			1:  atan_turn = ZW'(64'sd316933406);
			2:  atan_turn = ZW'(64'sd167458907);
			3:  atan_turn = ZW'(64'sd85004756);
			4:  atan_turn = ZW'(64'sd42667331);
			5:  atan_turn = ZW'(64'sd21354465);
			6:  atan_turn = ZW'(64'sd10679838);
			7:  atan_turn = ZW'(64'sd5340245);
			8:  atan_turn = ZW'(64'sd2670163);
			9:  atan_turn = ZW'(64'sd1335087);
			10: atan_turn = ZW'(64'sd667544);
			11: atan_turn = ZW'(64'sd333772);
			12: atan_turn = ZW'(64'sd166886);
			13: atan_turn = ZW'(64'sd83443);
			14: atan_turn = ZW'(64'sd41722);
			15: atan_turn = ZW'(64'sd20861);
			16: atan_turn = ZW'(64'sd10430);
			17: atan_turn = ZW'(64'sd5215);
			18: atan_turn = ZW'(64'sd2608);
			19: atan_turn = ZW'(64'sd1304);
			20: atan_turn = ZW'(64'sd652);
			21: atan_turn = ZW'(64'sd326);
			22: atan_turn = ZW'(64'sd163);
			23: atan_turn = ZW'(64'sd81);
			24: atan_turn = ZW'(64'sd41);
			25: atan_turn = ZW'(64'sd20);
			26: atan_turn = ZW'(64'sd10);
			27: atan_turn = ZW'(64'sd5);
			default: atan_turn = '0;
		endcase
	endfunction

endpackage

// ===== rtl/core/beacon_constellation_pose_top.sv =====
// channel   signals                                    transfer
// frame in  start, busy, point_mode, x1..x4, y1..y4    edge with start high and busy low
// pose out  done, pos_x, pos_y, heading, located       edge ending the cycle done is high
//
// Fully pipelined: one frame per cycle through the vectoring CORDIC followed by the
// rotation CORDIC, one stage per step.
// Reset clears only the stage valid bits and done; busy is always low.
// The receiver cannot stall, so the pipeline never holds.
module beacon_constellation_pose_top #(
	parameter int COORD_BITS = bcp_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = bcp_pkg::ANGLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         point_mode,
	input  logic [COORD_BITS-1:0]        x1,
	input  logic [COORD_BITS-1:0]        y1,
	input  logic [COORD_BITS-1:0]        x2,
	input  logic [COORD_BITS-1:0]        y2,
	input  logic [COORD_BITS-1:0]        x3,
	input  logic [COORD_BITS-1:0]        y3,
	input  logic [COORD_BITS-1:0]        x4,
	input  logic [COORD_BITS-1:0]        y4,
	output logic signed [COORD_BITS+1:0] pos_x,
	output logic signed [COORD_BITS+1:0] pos_y,
	output logic signed [ANGLE_BITS-1:0] heading,
	output logic                         located,
	output logic                         done
);

	localparam int CW    = COORD_BITS;
	localparam int DW    = 2 * CW + 1;
	localparam int RW    = DW + 4;
	localparam int XW    = CW + 28;
	localparam int ZW    = bcp_pkg::ZW;
	localparam int TS    = 32 - ANGLE_BITS;
	localparam int FB    = bcp_pkg::FRAC_BITS;
	localparam int STEPS = bcp_pkg::CORDIC_STEPS;
	localparam int LAT   = 2 * STEPS + 9;

	assign busy = 1'b0;

	function automatic logic [DW-1:0] sqd(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
			input logic [CW-1:0] bx, input logic [CW-1:0] by);
		logic signed [CW:0]     ddx;
		logic signed [CW:0]     ddy;
		logic signed [2*CW+1:0] sx;
		logic signed [2*CW+1:0] sy;
		logic [2*CW+1:0]        sum;
		ddx = $signed({1'b0, ax}) - $signed({1'b0, bx});
		ddy = $signed({1'b0, ay}) - $signed({1'b0, by});
		sx  = ddx * ddx;
		sy  = ddy * ddy;
		sum = sx + sy;
		sqd = sum[DW-1:0];
	endfunction

	function automatic logic [CW+1:0] finish(input logic signed [XW-1:0] v);
		logic signed [XW:0] r;
		logic signed [XW:0] t;
		r = ($signed({v[XW-1], v}) + $signed((XW+1)'(2048))) >>> 12;
		if (r[XW]) begin
			t = -((-r) >>> 12);
		end else begin
			t = r >>> 12;
		end
		finish = t[CW+1:0];
	endfunction

	// s1: input capture
	logic          v_s1;
	logic          mode_s1;
	logic [CW-1:0] px_s1 [4];
	logic [CW-1:0] py_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= point_mode;
		px_s1[0] <= x1; py_s1[0] <= y1;
		px_s1[1] <= x2; py_s1[1] <= y2;
		px_s1[2] <= x3; py_s1[2] <= y3;
		px_s1[3] <= x4; py_s1[3] <= y4;
	end

	// s2: squared distances
	logic          v_s2;
	logic          mode_s2;
	logic [CW-1:0] px_s2 [4];
	logic [CW-1:0] py_s2 [4];
	logic [DW-1:0] d_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		for (int p = 0; p < 6; p++) begin
			d_s2[p] <= sqd(px_s1[bcp_pkg::pair_a(p)], py_s1[bcp_pkg::pair_a(p)],
				px_s1[bcp_pkg::pair_b(p)], py_s1[bcp_pkg::pair_b(p)]);
		end
	end

	// s3: max and min
	logic          v_s3;
	logic          mode_s3;
	logic [CW-1:0] px_s3 [4];
	logic [CW-1:0] py_s3 [4];
	logic [DW-1:0] d_s3 [6];
	logic [DW-1:0] mx_s3;
	logic [DW-1:0] mn_s3;
	logic [DW-1:0] cand [6];
	logic [DW-1:0] mx_c;
	logic [DW-1:0] mn_c;

	always_comb begin
		if (mode_s2) begin
			cand = d_s2;
		end else begin
			// three points use pairs 12, 13, 23
			cand[0] = d_s2[0];
			cand[1] = d_s2[1];
			cand[2] = d_s2[3];
			cand[3] = d_s2[0];
			cand[4] = d_s2[0];
			cand[5] = d_s2[0];
		end
		mx_c = cand[0];
		mn_c = cand[0];
		for (int i = 1; i < 6; i++) begin
			if (cand[i] > mx_c) mx_c = cand[i];
			if (cand[i] < mn_c) mn_c = cand[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		d_s3    <= d_s2;
		mx_s3   <= mx_c;
		mn_s3   <= mn_c;
	end

	// s4: pick the far pair B, D
	logic              v_s4;
	logic              found_s4;
	bcp_pkg::pt_idx_t  b_s4;
	bcp_pkg::pt_idx_t  e_s4;
	logic [CW-1:0]     px_s4 [4];
	logic [CW-1:0]     py_s4 [4];
	logic              found_c;
	bcp_pkg::pt_idx_t  b_c;
	bcp_pkg::pt_idx_t  e_c;
	logic              near_a [6];
	logic [RW-1:0]     mx_w;
	logic [RW-1:0]     mn_w;
	logic              ratio_ok;

	always_comb begin
		for (int p = 0; p < 6; p++) begin
			near_a[p] = 1'b0;
			for (int k = 0; k < 4; k++) begin
				if (k != int'(bcp_pkg::pair_a(p)) && k != int'(bcp_pkg::pair_b(p)) &&
						mn_s3 == d_s3[bcp_pkg::pair_of(int'(bcp_pkg::pair_a(p)), k)]) begin
					near_a[p] = 1'b1;
				end
			end
		end
		mx_w     = RW'(mx_s3);
		mn_w     = RW'(mn_s3);
		ratio_ok = !(mx_w < (mn_w << 1)) &&
			!(!(mx_w > (mn_w << 2)) && (mx_w * RW'(5)) < (mn_w << 4));
		found_c = 1'b0;
		b_c     = 2'd0;
		e_c     = 2'd0;
		if (mode_s3) begin
			for (int p = 0; p < 6; p++) begin
				if (!found_c && mx_s3 == d_s3[p]) begin
					found_c = 1'b1;
					b_c     = near_a[p] ? bcp_pkg::pair_a(p) : bcp_pkg::pair_b(p);
					e_c     = near_a[p] ? bcp_pkg::pair_b(p) : bcp_pkg::pair_a(p);
				end
			end
		end else if (ratio_ok) begin
			found_c = 1'b1;
			if (mx_s3 == d_s3[0]) begin
				b_c = (mn_s3 == d_s3[1]) ? 2'd0 : 2'd1;
				e_c = (mn_s3 == d_s3[1]) ? 2'd1 : 2'd0;
			end else if (mx_s3 == d_s3[1]) begin
				b_c = (mn_s3 == d_s3[0]) ? 2'd0 : 2'd2;
				e_c = (mn_s3 == d_s3[0]) ? 2'd2 : 2'd0;
			end else begin
				b_c = (mn_s3 == d_s3[1]) ? 2'd2 : 2'd1;
				e_c = (mn_s3 == d_s3[1]) ? 2'd1 : 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		found_s4 <= found_c;
		b_s4     <= b_c;
		e_s4     <= e_c;
		px_s4    <= px_s3;
		py_s4    <= py_s3;
	end

	// s5: difference vector and midpoint
	logic              v_s5;
	logic              found_s5;
	logic              zero_s5;
	logic signed [CW:0] dx_s5;
	logic signed [CW:0] dy_s5;
	logic [CW-1:0]     cx_s5;
	logic [CW-1:0]     cy_s5;
	logic signed [CW:0] dx_c;
	logic signed [CW:0] dy_c;
	logic [CW:0]       sx_c;
	logic [CW:0]       sy_c;

	always_comb begin
		dx_c = $signed({1'b0, px_s4[b_s4]}) - $signed({1'b0, px_s4[e_s4]});
		dy_c = $signed({1'b0, py_s4[b_s4]}) - $signed({1'b0, py_s4[e_s4]});
		sx_c = {1'b0, px_s4[b_s4]} + {1'b0, px_s4[e_s4]};
		sy_c = {1'b0, py_s4[b_s4]} + {1'b0, py_s4[e_s4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		found_s5 <= found_s4;
		zero_s5  <= (dx_c == '0) && (dy_c == '0);
		dx_s5    <= dx_c;
		dy_s5    <= dy_c;
		cx_s5    <= sx_c[CW:1];
		cy_s5    <= sy_c[CW:1];
	end

	// vectoring CORDIC: angle of (dy, dx); index 0 is the quadrant fold
	logic                 vv_s [STEPS+1];
	logic signed [XW-1:0] vx_s [STEPS+1];
	logic signed [XW-1:0] vy_s [STEPS+1];
	logic signed [ZW-1:0] vz_s [STEPS+1];
	logic                 vf_s [STEPS+1];
	logic                 vzr_s [STEPS+1];
	logic [CW-1:0]        vcx_s [STEPS+1];
	logic [CW-1:0]        vcy_s [STEPS+1];
	logic signed [XW-1:0] fx_c;
	logic signed [XW-1:0] fy_c;

	always_comb begin
		fx_c = XW'(dy_s5) <<< FB;
		fy_c = XW'(dx_s5) <<< FB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else begin
			vv_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		vf_s[0]  <= found_s5;
		vzr_s[0] <= zero_s5;
		vcx_s[0] <= cx_s5;
		vcy_s[0] <= cy_s5;
		if (fx_c[XW-1]) begin
			if (!fy_c[XW-1]) begin
				vx_s[0] <= fy_c;
				vy_s[0] <= -fx_c;
				vz_s[0] <= bcp_pkg::QUARTER_TURN;
			end else begin
				vx_s[0] <= -fy_c;
				vy_s[0] <= fx_c;
				vz_s[0] <= -bcp_pkg::QUARTER_TURN;
			end
		end else begin
			vx_s[0] <= fx_c;
			vy_s[0] <= fy_c;
			vz_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[i+1] <= 1'b0;
			end else begin
				vv_s[i+1] <= vv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			vf_s[i+1]  <= vf_s[i];
			vzr_s[i+1] <= vzr_s[i];
			vcx_s[i+1] <= vcx_s[i];
			vcy_s[i+1] <= vcy_s[i];
			if (!vy_s[i][XW-1]) begin
				vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] + bcp_pkg::atan_turn(i);
			end else begin
				vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] - bcp_pkg::atan_turn(i);
			end
		end
	end

	// heading rounding and gain prescale
	logic                         v_sh;
	logic                         found_sh;
	logic signed [ANGLE_BITS-1:0] hs_sh;
	logic signed [XW-1:0]         gx_sh;
	logic signed [XW-1:0]         gy_sh;
	logic signed [ZW-1:0]         hsum_c;
	logic [CW+29:0]               gpx_c;
	logic [CW+29:0]               gpy_c;

	always_comb begin
		hsum_c = vz_s[STEPS] + $signed(ZW'(64'd1 << (TS - 1)));
		gpx_c  = (CW+30)'(vcx_s[STEPS]) * (CW+30)'(bcp_pkg::GAIN_INV);
		gpy_c  = (CW+30)'(vcy_s[STEPS]) * (CW+30)'(bcp_pkg::GAIN_INV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sh <= 1'b0;
		end else begin
			v_sh <= vv_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		found_sh <= vf_s[STEPS];
		hs_sh    <= vzr_s[STEPS] ? '0 : hsum_c[TS+ANGLE_BITS-1:TS];
		gx_sh    <= $signed(XW'(gpx_c[CW+29:30-FB]));
		gy_sh    <= $signed(XW'(gpy_c[CW+29:30-FB]));
	end

	// rotation CORDIC by the rounded heading; index 0 is the quadrant fold
	logic                         rv_s [STEPS+1];
	logic signed [XW-1:0]         rx_s [STEPS+1];
	logic signed [XW-1:0]         ry_s [STEPS+1];
	logic signed [ZW-1:0]         rz_s [STEPS+1];
	logic                         rf_s [STEPS+1];
	logic signed [ANGLE_BITS-1:0] rh_s [STEPS+1];
	logic signed [ZW-1:0]         zt_c;

	always_comb begin
		zt_c = ZW'(hs_sh);
		zt_c = zt_c <<< TS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s[0] <= 1'b0;
		end else begin
			rv_s[0] <= v_sh;
		end
	end

	always_ff @(posedge clk) begin
		rf_s[0] <= found_sh;
		rh_s[0] <= hs_sh;
		if (zt_c > bcp_pkg::QUARTER_TURN) begin
			rx_s[0] <= -gy_sh;
			ry_s[0] <= gx_sh;
			rz_s[0] <= zt_c - bcp_pkg::QUARTER_TURN;
		end else if (zt_c < -bcp_pkg::QUARTER_TURN) begin
			rx_s[0] <= gy_sh;
			ry_s[0] <= -gx_sh;
			rz_s[0] <= zt_c + bcp_pkg::QUARTER_TURN;
		end else begin
			rx_s[0] <= gx_sh;
			ry_s[0] <= gy_sh;
			rz_s[0] <= zt_c;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[i+1] <= 1'b0;
			end else begin
				rv_s[i+1] <= rv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rf_s[i+1] <= rf_s[i];
			rh_s[i+1] <= rh_s[i];
			if (!rz_s[i][ZW-1]) begin
				rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
				ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
				rz_s[i+1] <= rz_s[i] - bcp_pkg::atan_turn(i);
			end else begin
				rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
				ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
				rz_s[i+1] <= rz_s[i] + bcp_pkg::atan_turn(i);
			end
		end
	end

	// output register; not located forces zeros
	logic                         done_q;
	logic                         located_q;
	logic signed [CW+1:0]         pos_x_q;
	logic signed [CW+1:0]         pos_y_q;
	logic signed [ANGLE_BITS-1:0] heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rv_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		located_q <= rf_s[STEPS];
		pos_x_q   <= rf_s[STEPS] ? $signed(finish(rx_s[STEPS])) : '0;
		pos_y_q   <= rf_s[STEPS] ? $signed(finish(ry_s[STEPS])) : '0;
		heading_q <= rf_s[STEPS] ? rh_s[STEPS] : '0;
	end

	assign done    = done_q;
	assign located = located_q;
	assign pos_x   = pos_x_q;
	assign pos_y   = pos_y_q;
	assign heading = heading_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted frame did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(rv_s[STEPS]))
		else $error("result strobe without a frame in the pipeline");

	a_unlocated_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !located) |-> (pos_x == '0 && pos_y == '0 && heading == '0))
		else $error("unlocated result carries nonzero fields");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a pipeline that cannot stall");
`endif

endmodule

// ===== sim/beacon_constellation_pose_top_tb.sv =====
`timescale 1ns / 1ps

module beacon_constellation_pose_top_tb;

	localparam int CB = bcp_pkg::COORD_BITS_DEF;
	localparam int AB = bcp_pkg::ANGLE_BITS_DEF;
	localparam int PB = CB + 2;
	localparam int LATENCY = 2 * bcp_pkg::CORDIC_STEPS + 9;
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};
	localparam int N_DIRECTED = 14;
	localparam int N_RANDOM = 1036;

	typedef struct packed {
		logic          mode;
		logic [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	typedef struct packed {
		logic signed [PB-1:0] px;
		logic signed [PB-1:0] py;
		logic signed [AB-1:0] hdg;
		logic                 loc;
	} pose_t;

	// directed frame plus typed expectation where it is obvious
	typedef struct packed {
		frame_t f;
		logic   typed;
		pose_t  p;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic point_mode = 1'b0;
	logic [CB-1:0] x1 = '0, y1 = '0, x2 = '0, y2 = '0, x3 = '0, y3 = '0, x4 = '0, y4 = '0;
	logic signed [PB-1:0] pos_x, pos_y;
	logic signed [AB-1:0] heading;
	logic located, done;

	pose_t pending_poses[$];
	int err_count = 0;
	row_t dir_rows[N_DIRECTED];

	beacon_constellation_pose_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_mode(point_mode),
		.x1(x1), .y1(y1), .x2(x2), .y2(y2), .x3(x3), .y3(y3), .x4(x4), .y4(y4),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .located(located), .done(done)
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint trunc_shr(input longint v, input int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	function automatic longint dist2(input longint ax, ay, bx, by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	function automatic longint atan_of(input longint vx, input longint vy);
		longint x, y, z, t, xs, ys;
		x = vx <<< bcp_pkg::FRAC_BITS;
		y = vy <<< bcp_pkg::FRAC_BITS;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 64'sd1 <<< 30;
			end else begin
				t = x; x = -y; y = t; z = -(64'sd1 <<< 30);
			end
		end
		for (int i = 0; i < bcp_pkg::CORDIC_STEPS; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(bcp_pkg::atan_turn(i));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(bcp_pkg::atan_turn(i));
			end
		end
		return z;
	endfunction

	function automatic longint round_coord(input longint v);
		return trunc_shr(floor_shr(v + (64'sd1 <<< (bcp_pkg::FRAC_BITS - 13)),
			bcp_pkg::FRAC_BITS - 12), 12);
	endfunction

	function automatic pose_t predict_pose(input frame_t f);
		longint px[4], py[4], d[6], mx, mn, dx, dy, cx, cy, hs, h, x, y, z, t, xs, ys, q;
		int pa[6], pbb[6], n, b, e, a, c;
		bit found, near_a;
		pose_t r;
		pa = '{0, 0, 0, 1, 1, 2};
		pbb = '{1, 2, 3, 2, 3, 3};
		px = '{f.x1, f.x2, f.x3, f.x4};
		py = '{f.y1, f.y2, f.y3, f.y4};
		q = 64'sd1 <<< 30;
		found = 0; b = 0; e = 0; hs = 0;
		n = f.mode ? 6 : 3;
		if (f.mode) begin
			for (int i = 0; i < 6; i++) d[i] = dist2(px[pa[i]], py[pa[i]], px[pbb[i]], py[pbb[i]]);
		end else begin
			d[0] = dist2(px[0], py[0], px[1], py[1]);
			d[1] = dist2(px[0], py[0], px[2], py[2]);
			d[2] = dist2(px[1], py[1], px[2], py[2]);
		end
		mx = d[0]; mn = d[0];
		for (int i = 1; i < n; i++) begin
			if (d[i] > mx) mx = d[i];
			if (d[i] < mn) mn = d[i];
		end
		if (f.mode) begin
			for (int i = 0; i < 6 && !found; i++) begin
				if (mx == d[i]) begin
					a = pa[i]; c = pbb[i]; near_a = 0;
					for (int k = 0; k < 4; k++)
						if (k != a && k != c && mn == dist2(px[a], py[a], px[k], py[k]))
							near_a = 1;
					if (near_a) begin b = a; e = c; end else begin b = c; e = a; end
					found = 1;
				end
			end
		end else if (!(mx < 2 * mn) && !(!(mx > 4 * mn) && 5 * mx < 16 * mn)) begin
			if (mx == d[0]) begin
				if (mn == d[1]) begin b = 0; e = 1; end else begin b = 1; e = 0; end
			end else if (mx == d[1]) begin
				if (mn == d[0]) begin b = 0; e = 2; end else begin b = 2; e = 0; end
			end else begin
				if (mn == d[1]) begin b = 2; e = 1; end else begin b = 1; e = 2; end
			end
			found = 1;
		end
		r = '0;
		if (!found) return r;
		dx = px[b] - px[e];
		dy = py[b] - py[e];
		cx = (px[b] + px[e]) >>> 1;
		cy = (py[b] + py[e]) >>> 1;
		if (dx != 0 || dy != 0) begin
			h = floor_shr(atan_of(dy, dx) + (64'sd1 <<< (31 - AB)), 32 - AB);
			hs = longint'($signed(AB'(h)));
		end
		x = floor_shr(cx * longint'(bcp_pkg::GAIN_INV), 30 - bcp_pkg::FRAC_BITS);
		y = floor_shr(cy * longint'(bcp_pkg::GAIN_INV), 30 - bcp_pkg::FRAC_BITS);
		z = hs <<< (32 - AB);
		if (z > q) begin
			t = x; x = -y; y = t; z -= q;
		end else if (z < -q) begin
			t = x; x = y; y = -t; z += q;
		end
		for (int i = 0; i < bcp_pkg::CORDIC_STEPS; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (z >= 0) begin
				x = x - ys; y = y + xs; z -= longint'(bcp_pkg::atan_turn(i));
			end else begin
				x = x + ys; y = y - xs; z += longint'(bcp_pkg::atan_turn(i));
			end
		end
		r.px = PB'(round_coord(x));
		r.py = PB'(round_coord(y));
		r.hdg = AB'(hs);
		r.loc = 1'b1;
		return r;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int k;
		f = frame_t'(FRAME_W'({$urandom, $urandom, $urandom}));
		k = $urandom_range(0, 9);
		if (k < 3) begin
			// cluster near an extreme corner to hit edges
			f.x1 = $urandom_range(0, 3) ? f.x1 : CMAX;
			f.y2 = $urandom_range(0, 3) ? f.y2 : '0;
		end else if (k < 6) begin
			// three-point layouts tuned toward the ratio thresholds
			f.x2 = f.x1; f.y2 = f.y1 + CB'($urandom_range(1, 40));
			f.x3 = f.x1 + CB'($urandom_range(0, 80)); f.y3 = f.y1 + CB'($urandom_range(0, 80));
		end else if (k == 6) begin
			f.x4 = f.x3; f.y4 = f.y3;
		end
		return f;
	endfunction

	task automatic drive_frame(input frame_t f);
		point_mode <= f.mode;
		x1 <= f.x1; y1 <= f.y1; x2 <= f.x2; y2 <= f.y2;
		x3 <= f.x3; y3 <= f.y3; x4 <= f.x4; y4 <= f.y4;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// result checker: every done cycle pops the oldest expectation
	always @(posedge clk) begin
		pose_t want;
		if (arst_n && done) begin
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected pose", 1, 0);
			end else begin
				want = pending_poses.pop_front();
				if (located !== want.loc) report_mismatch("located", located, want.loc);
				if (pos_x !== want.px) report_mismatch("pos_x", pos_x, want.px);
				if (pos_y !== want.py) report_mismatch("pos_y", pos_y, want.py);
				if (heading !== want.hdg) report_mismatch("heading", heading, want.hdg);
			end
		end
	end

	initial begin
		frame_t f;
		pose_t p;
		int gap, burst, wait_cycles;
		// all points equal: every ratio test fails, so the pair is still chosen
		dir_rows[0] = '{'{1'b0, '0, '0, '0, '0, '0, '0, '0, '0}, 1'b1,
			'{12'sd0, 12'sd0, 16'sd0, 1'b1}};
		dir_rows[1] = '{'{1'b1, '0, '0, '0, '0, '0, '0, '0, '0}, 1'b1,
			'{12'sd0, 12'sd0, 16'sd0, 1'b1}};
		dir_rows[2] = '{'{1'b1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0};
		dir_rows[3] = '{'{1'b0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, '0, '0}, 1'b0, '0};
		// three points: ratio below 2, between 2 and 3.2, between 3.2 and 4, above 4
		dir_rows[4] = '{'{1'b0, 10'd0, 10'd0, 10'd10, 10'd0, 10'd5, 10'd9, '0, '0}, 1'b1, '0};
		dir_rows[5] = '{'{1'b0, 10'd0, 10'd0, 10'd10, 10'd0, 10'd0, 10'd8, '0, '0}, 1'b1, '0};
		dir_rows[6] = '{'{1'b0, 10'd0, 10'd0, 10'd10, 10'd0, 10'd0, 10'd6, '0, '0}, 1'b0,
			'0};
		dir_rows[7] = '{'{1'b0, 10'd0, 10'd0, 10'd0, 10'd3, 10'd20, 10'd0, '0, '0}, 1'b0, '0};
		dir_rows[8] = '{'{1'b0, 10'd5, 10'd5, 10'd5, 10'd5, 10'd900, 10'd7, '0, '0}, 1'b0,
			'0};
		dir_rows[9] = '{'{1'b1, '0, '0, CMAX, CMAX, '0, CMAX, CMAX, '0}, 1'b0, '0};
		dir_rows[10] = '{'{1'b1, CMAX, '0, '0, CMAX, 10'd1, 10'd2, 10'd3, 10'd4}, 1'b0, '0};
		dir_rows[11] = '{'{1'b0, CMAX, '0, '0, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0};
		dir_rows[12] = '{'{1'b1, 10'd512, 10'd512, 10'd0, 10'd512, 10'd512, 10'd0, 10'd1023,
			10'd1023}, 1'b0, '0};
		dir_rows[13] = '{'{1'b0, 10'd100, 10'd0, 10'd0, 10'd0, 10'd50, 10'd0, '0, '0}, 1'b0,
			'0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			p = predict_pose(dir_rows[i].f);
			if (dir_rows[i].typed && p !== dir_rows[i].p)
				report_mismatch($sformatf("predictor row %0d", i), p, dir_rows[i].p);
			pending_poses.push_back(dir_rows[i].typed ? dir_rows[i].p : p);
			drive_frame(dir_rows[i].f);
		end

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst = $urandom_range(1, 40);
			end
			f = random_frame();
			pending_poses.push_back(predict_pose(f));
			drive_frame(f);
			burst--;
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_poses.size() != 0 && wait_cycles < 20 * LATENCY) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (LATENCY) @(negedge clk);
		if (err_count == 0 && pending_poses.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
